FILE: sv/lbg_pkg.sv
// Shared types and constants for the LCD bar graph cell writer.
// No dependencies.
`default_nettype none

package lbg_pkg;

    localparam int MAX_COLS_DEF = 40;
    localparam int LEVEL_W      = 7;
    localparam int FS_W         = 15;
    localparam int VAL_W        = 16;
    localparam int CFG_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = $clog2(LEVEL_W);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd2;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [1:0] CODE_FULL  = 2'd0;
    localparam logic [1:0] CODE_EMPTY = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_DSTART = 7'b0000100,
        ST_DWAIT  = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_CHARS  = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/lbg_divider.sv
// Restoring divider, one quotient bit per cycle, for the bar level.
// Depends on lbg_pkg. Quotient must fit in LEVEL_W bits.
`default_nettype none

module lbg_divider #(
    parameter int NUM_W = 23
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [NUM_W-1:0]           num,
    input  wire logic [lbg_pkg::FS_W-1:0]   den,
    output logic [lbg_pkg::LEVEL_W-1:0]     quot,
    output lbg_pkg::div_stat_t              stat
);

    logic [NUM_W-1:0]                 rem_reg, rem_next;
    logic [lbg_pkg::FS_W-1:0]         den_reg, den_next;
    logic [lbg_pkg::STEP_W-1:0]       k_reg, k_next;
    logic [lbg_pkg::LEVEL_W-1:0]      quot_reg, quot_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [NUM_W-1:0]                 trial;
    logic                             fits;

    assign trial = NUM_W'(den_reg) << k_reg;
    assign fits  = rem_reg >= trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        k_next    = k_reg;
        quot_next = quot_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            k_next    = lbg_pkg::STEP_W'(lbg_pkg::LEVEL_W - 1);
            quot_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next         = rem_reg - trial;
                quot_next[k_reg] = 1'b1;
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - lbg_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        k_reg    <= k_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: sv/lcd_bar_graph_cell_writer.sv
// Top level of the LCD bar graph cell writer: sequencer, cache, output words.
// Depends on lbg_pkg and lbg_divider.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one word: level_value (signed)
//   and full_scale. The value is clamped to 0..full_scale and scaled to a
//   level q = value*cols*3/full_scale. If q matches the last drawn level,
//   no output word is produced. Otherwise the output channel
//   (out_valid/out_stall) carries one cursor move word and then one
//   character word per column, the last flagged by last_item.
//   Sequence: accept, a multiply state, divider start, seven divider steps
//   and a compare with the cached level; the output words then follow,
//   one word per cycle while not stalled.
//   in_stall is high from accept until the last word leaves, or until the
//   compare if the level is unchanged, so no new word is taken meanwhile.
//   A stalled output word holds until taken.
//   Reset: registers return to num_cols 16, start_col 0, start_row 0,
//   and the level cache is marked invalid.
//   Configuration: cfg_we/cfg_index/cfg_data, written while idle.
`default_nettype none

module lcd_bar_graph_cell_writer #(
    parameter int MAX_COLS = lbg_pkg::MAX_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbg_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lbg_pkg::VAL_W-1:0]      level_value,
    input  wire logic [lbg_pkg::FS_W-1:0]       full_scale,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                item_kind,
    output logic [5:0]                          cursor_col,
    output logic [1:0]                          cursor_row,
    output logic [1:0]                          char_code,
    output logic                                last_item
);

    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int PROD_W = lbg_pkg::FS_W + COL_W + 2;
    localparam int NUM_W  = (PROD_W > lbg_pkg::FS_W + lbg_pkg::LEVEL_W) ?
                            PROD_W : lbg_pkg::FS_W + lbg_pkg::LEVEL_W;
    localparam int RES_W  = lbg_pkg::LEVEL_W + 1;

    lbg_pkg::state_t                 state_reg, state_next;
    logic [5:0]                      num_cols_reg;
    logic [5:0]                      start_col_reg;
    logic [1:0]                      start_row_reg;
    logic [lbg_pkg::LEVEL_W-1:0]     cached_level_reg, cached_level_next;
    logic                            cache_valid_reg, cache_valid_next;

    logic [COL_W-1:0]                cols_reg, cols_next;
    logic [5:0]                      col_pos_reg, col_pos_next;
    logic [1:0]                      row_pos_reg, row_pos_next;
    logic [lbg_pkg::FS_W-1:0]        fs_reg, fs_next;
    logic [lbg_pkg::FS_W-1:0]        v_reg, v_next;
    logic [NUM_W-1:0]                prod_reg, prod_next;
    logic signed [RES_W-1:0]         resid_reg, resid_next;
    logic [COL_W-1:0]                cnt_reg, cnt_next;

    logic [5:0]                      cols_sat;
    logic [COL_W+1:0]                cols3;
    logic [lbg_pkg::FS_W-1:0]        v_clamp;
    logic [lbg_pkg::LEVEL_W-1:0]     q;
    logic [lbg_pkg::LEVEL_W-1:0]     div_quot;
    lbg_pkg::div_stat_t              div_stat;
    logic                            div_start;
    logic                            in_take, out_take, is_last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg  <= 6'd16;
            start_col_reg <= 6'd0;
            start_row_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbg_pkg::CFG_NUM_COLS:  num_cols_reg  <= cfg_data;
                lbg_pkg::CFG_START_COL: start_col_reg <= cfg_data;
                lbg_pkg::CFG_START_ROW: start_row_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (num_cols_reg == 6'd0)
            cols_sat = 6'd1;
        else if (num_cols_reg > 6'(MAX_COLS))
            cols_sat = 6'(MAX_COLS);
        else
            cols_sat = num_cols_reg;
    end

    always_comb
    begin
        if (level_value[lbg_pkg::VAL_W-1])
            v_clamp = '0;
        else if (level_value[lbg_pkg::FS_W-1:0] > full_scale)
            v_clamp = full_scale;
        else
            v_clamp = level_value[lbg_pkg::FS_W-1:0];
    end

    assign cols3 = (COL_W+2)'(cols_reg) + ((COL_W+2)'(cols_reg) << 1);
    assign q     = (fs_reg == '0) ? '0 : div_quot;

    assign in_stall  = (state_reg != lbg_pkg::ST_IDLE);
    assign out_valid = (state_reg == lbg_pkg::ST_MOVE) || (state_reg == lbg_pkg::ST_CHARS);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign is_last   = (cnt_reg == cols_reg - COL_W'(1));
    assign div_start = (state_reg == lbg_pkg::ST_DSTART);

    lbg_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (fs_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next        = state_reg;
        cached_level_next = cached_level_reg;
        cache_valid_next  = cache_valid_reg;
        cols_next         = cols_reg;
        col_pos_next      = col_pos_reg;
        row_pos_next      = row_pos_reg;
        fs_next           = fs_reg;
        v_next            = v_reg;
        prod_next         = prod_reg;
        resid_next        = resid_reg;
        cnt_next          = cnt_reg;
        unique case (state_reg)
            lbg_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    cols_next    = COL_W'(cols_sat);
                    col_pos_next = start_col_reg;
                    row_pos_next = start_row_reg;
                    fs_next      = full_scale;
                    v_next       = v_clamp;
                    state_next   = lbg_pkg::ST_MUL;
                end
            end
            lbg_pkg::ST_MUL:
            begin
                prod_next  = NUM_W'(NUM_W'(v_reg) * NUM_W'(cols3));
                state_next = lbg_pkg::ST_DSTART;
            end
            lbg_pkg::ST_DSTART:
            begin
                state_next = lbg_pkg::ST_DWAIT;
            end
            lbg_pkg::ST_DWAIT:
            begin
                if (div_stat.done)
                begin
                    if (cache_valid_reg && cached_level_reg == q)
                    begin
                        state_next = lbg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cached_level_next = q;
                        cache_valid_next  = 1'b1;
                        resid_next        = $signed({1'b0, q});
                        cnt_next          = '0;
                        state_next        = lbg_pkg::ST_MOVE;
                    end
                end
            end
            lbg_pkg::ST_MOVE:
            begin
                if (out_take)
                    state_next = lbg_pkg::ST_CHARS;
            end
            lbg_pkg::ST_CHARS:
            begin
                if (out_take)
                begin
                    resid_next = resid_reg - RES_W'(3);
                    cnt_next   = cnt_reg + COL_W'(1);
                    if (is_last)
                        state_next = lbg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lbg_pkg::ST_IDLE;
            cached_level_reg <= '0;
            cache_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cached_level_reg <= cached_level_next;
            cache_valid_reg  <= cache_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg    <= cols_next;
        col_pos_reg <= col_pos_next;
        row_pos_reg <= row_pos_next;
        fs_reg      <= fs_next;
        v_reg       <= v_next;
        prod_reg    <= prod_next;
        resid_reg   <= resid_next;
        cnt_reg     <= cnt_next;
    end

    // output word
    always_comb
    begin
        if (state_reg == lbg_pkg::ST_CHARS)
        begin
            item_kind  = lbg_pkg::KIND_CHAR;
            cursor_col = '0;
            cursor_row = '0;
            last_item  = is_last;
            if (resid_reg >= RES_W'(3))
                char_code = lbg_pkg::CODE_FULL;
            else if (resid_reg > RES_W'(0))
                char_code = resid_reg[1:0];
            else
                char_code = lbg_pkg::CODE_EMPTY;
        end
        else
        begin
            item_kind  = lbg_pkg::KIND_MOVE;
            cursor_col = col_pos_reg;
            cursor_row = row_pos_reg;
            char_code  = '0;
            last_item  = 1'b0;
        end
    end

    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("output word while accepting input");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && last_item |=> !in_stall)
        else $error("not idle after last word");

    a_move_then_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && item_kind == lbg_pkg::KIND_MOVE |=> out_valid && item_kind == lbg_pkg::KIND_CHAR)
        else $error("cursor move not followed by character");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == lbg_pkg::ST_DWAIT)
        else $error("divider finished outside wait state");

    a_div_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == lbg_pkg::ST_DWAIT)
        else $error("divider running outside wait state");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for lcd_bar_graph_cell_writer: directed and random bar updates are checked
// word by word against a built-in bar predictor. Random valid/stall idling is applied.
// Depends on lbg_pkg and the RTL of lcd_bar_graph_cell_writer.
`timescale 1ns / 100ps

module tb_top;
    import lbg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic       kind;
        logic [5:0] col;
        logic [1:0] row;
        logic [1:0] code;
        logic       last;
    } bar_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [VAL_W-1:0]     level_value;
    logic [FS_W-1:0]      full_scale;
    logic                 out_valid;
    logic                 out_stall;
    logic                 item_kind;
    logic [5:0]           cursor_col;
    logic [1:0]           cursor_row;
    logic [1:0]           char_code;
    logic                 last_item;

    // predictor copy of registers and level cache
    logic [5:0]           bar_cols;
    logic [5:0]           bar_col;
    logic [1:0]           bar_row;
    logic [LEVEL_W-1:0]   drawn_level;
    logic                 drawn_valid;

    bar_word_t            bar_words_due[$];
    int                   mismatch_count;
    int                   send_gap_pct;
    int                   recv_stall_pct;

    lcd_bar_graph_cell_writer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level_value (level_value),
        .full_scale  (full_scale),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .item_kind   (item_kind),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .char_code   (char_code),
        .last_item   (last_item)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // expected words for one accepted word
    function automatic void draw_bar(input logic [VAL_W-1:0] val, input logic [FS_W-1:0] fs);
        int unsigned cols;
        int unsigned v;
        int unsigned q;
        int unsigned full;
        int unsigned part;
        bar_word_t   w;
        cols = bar_cols;
        if (cols == 0)
            cols = 1;
        if (cols > MAX_COLS_DEF)
            cols = MAX_COLS_DEF;
        if (val[VAL_W-1])
            v = 0;
        else if (val > fs)
            v = fs;
        else
            v = val;
        q = (fs == 0) ? 0 : (v * cols * 3) / fs;
        q = q & 127;
        if (drawn_valid && drawn_level == LEVEL_W'(q))
            return;
        full = q / 3;
        part = q % 3;
        w = '{kind: KIND_MOVE, col: bar_col, row: bar_row, code: 2'd0, last: 1'b0};
        bar_words_due.push_back(w);
        for (int i = 0; i < cols; i++)
        begin
            w = '{kind: KIND_CHAR, col: 6'd0, row: 2'd0, code: CODE_EMPTY,
                  last: (i + 1 == cols)};
            if (i < full)
                w.code = CODE_FULL;
            else if (i == full && part != 0)
                w.code = 2'(part);
            bar_words_due.push_back(w);
        end
        drawn_level = LEVEL_W'(q);
        drawn_valid = 1'b1;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        bar_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bar_words_due.size() == 0)
            begin
                $display("%0t ns: unexpected word kind=%0d col=%0d row=%0d code=%0d last=%0d",
                         $time, item_kind, cursor_col, cursor_row, char_code, last_item);
                mismatch_count++;
            end
            else
            begin
                want = bar_words_due.pop_front();
                check_field("item_kind", want.kind, item_kind);
                check_field("cursor_col", want.col, cursor_col);
                check_field("cursor_row", want.row, cursor_row);
                check_field("char_code", want.code, char_code);
                check_field("last_item", want.last, last_item);
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_word(input logic [VAL_W-1:0] val, input logic [FS_W-1:0] fs);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        level_value <= val;
        full_scale  <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        draw_bar(val, fs);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (bar_words_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_COLS)
            bar_cols = data;
        else if (idx == CFG_START_COL)
            bar_col = data;
        else if (idx == CFG_START_ROW)
            bar_row = data[1:0];
        @(negedge clk);
    endtask

    task automatic test_reset_levels();
        send_word(16'd0, 15'd1);
        send_word(16'd0, 15'd1);
        send_word(16'd32767, 15'd32767);
        send_word(16'h8000, 15'd32767);
        send_word(16'hffff, 15'd100);
        send_word(16'd32767, 15'd1);
        send_word(16'd1, 15'd48);
        send_word(16'd2, 15'd48);
        send_word(16'd5, 15'd0);
        send_word(16'd16384, 15'd32767);
        wait_idle();
    endtask

    task automatic test_column_limits();
        write_reg(CFG_NUM_COLS, 6'd0);
        send_word(16'd10, 15'd30);
        send_word(16'd30, 15'd30);
        wait_idle();
        write_reg(CFG_NUM_COLS, 6'd63);
        write_reg(CFG_START_COL, 6'd63);
        write_reg(CFG_START_ROW, 6'd3);
        send_word(16'd32767, 15'd32767);
        send_word(16'd1, 15'd120);
        wait_idle();
        write_reg(CFG_NUM_COLS, 6'd41);
        send_word(16'd60, 15'd120);
        wait_idle();
        write_reg(CFG_NUM_COLS, 6'd40);
        write_reg(CFG_START_COL, 6'd39);
        write_reg(CFG_START_ROW, 6'd1);
        send_word(16'd0, 15'd5);
        wait_idle();
        // same level after a column change: no redraw
        write_reg(CFG_NUM_COLS, 6'd8);
        send_word(16'd0, 15'd7);
        send_word(16'd7, 15'd7);
        wait_idle();
        write_reg(CFG_UNUSED_IDX, 6'h3f);
        send_word(16'd3, 15'd7);
        wait_idle();
        write_reg(CFG_NUM_COLS, 6'd1);
        write_reg(CFG_START_COL, 6'd0);
        write_reg(CFG_START_ROW, 6'd2);
        send_word(16'd2, 15'd3);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [VAL_W-1:0] val;
        logic [FS_W-1:0]  fs;
        logic [VAL_W-1:0] prev_val;
        logic [FS_W-1:0]  prev_fs;
        int unsigned      sel;
        prev_val = '0;
        prev_fs  = 15'd1;
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
            begin
                send_gap_pct   = 15;
                recv_stall_pct = 81;
            end
            else if (ph == 1)
            begin
                send_gap_pct   = 81;
                recv_stall_pct = 15;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            for (int blk = 0; blk < 2; blk++)
            begin
                wait_idle();
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    write_reg(CFG_NUM_COLS, 6'd40);
                else if (sel == 1)
                    write_reg(CFG_NUM_COLS, CFG_W'($urandom_range(41, 63)));
                else if (sel == 2)
                    write_reg(CFG_NUM_COLS, 6'd0);
                else
                    write_reg(CFG_NUM_COLS, CFG_W'($urandom_range(1, 12)));
                write_reg(CFG_START_COL, CFG_W'($urandom_range(0, 63)));
                write_reg(CFG_START_ROW, CFG_W'($urandom_range(0, 3)));
                for (int k = 0; k < 35; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        fs = FS_W'($urandom_range(1, 16));
                    else
                        fs = FS_W'($urandom());
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        val = VAL_W'($urandom()) | 16'h8000;
                    else if (sel == 1)
                        val = VAL_W'($urandom_range(fs, 32767));
                    else if (sel == 2)
                    begin
                        val = prev_val;
                        fs  = prev_fs;
                    end
                    else
                        val = VAL_W'($urandom_range(0, fs));
                    send_word(val, fs);
                    prev_val = val;
                    prev_fs  = fs;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        level_value    = '0;
        full_scale     = 15'd1;
        out_stall      = 1'b0;
        mismatch_count = 0;
        send_gap_pct   = 15;
        recv_stall_pct = 81;
        bar_cols       = 6'd16;
        bar_col        = 6'd0;
        bar_row        = 2'd0;
        drawn_level    = '0;
        drawn_valid    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_levels();
        test_column_limits();
        test_random_traffic();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
